/* rtl/pcxrle_pkg.sv */
package pcxrle_pkg;

	localparam logic [7:0] CODE_MARK = 8'hC0;
	localparam logic [5:0] RUN_MAX   = 6'd63;

	localparam int MAX_BYTES      = 4;
	localparam int IDX_W          = $clog2(MAX_BYTES);
	localparam int NB_W           = $clog2(MAX_BYTES + 1);
	localparam int FIFO_DEPTH_DEF = 4;

	// bytes one input transaction leaves behind, in output order
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] data;
		logic [NB_W-1:0]           nbytes;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/pcxrle_front.sv */
module pcxrle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          pixel,
	input  logic                line_end,
	input  logic                q_full,
	output logic                q_push,
	output pcxrle_pkg::entry_t  q_entry
);

	typedef struct packed {
		logic [1:0][7:0] data;
		logic [1:0]      n;
	} code_t;

	logic [7:0] held_q;
	logic [5:0] len_q;
	logic       start_q;

	logic [7:0] nxt_held;
	logic [5:0] nxt_len;
	logic       nxt_start;
	logic [5:0] inc_len;
	logic [5:0] r0_cnt;
	logic [5:0] r1_cnt;
	code_t      c0;
	code_t      c1;
	logic       accept;

	function automatic code_t run_code(input logic [7:0] val, input logic [5:0] cnt);
		code_t c;
		c.data = '0;
		c.n    = 2'd0;
		if (cnt == 6'd0) begin
			c.n = 2'd0;
		end else if (cnt == 6'd1 &&
			(val & pcxrle_pkg::CODE_MARK) != pcxrle_pkg::CODE_MARK) begin
			c.data[0] = val;
			c.n       = 2'd1;
		end else begin
			c.data[0] = pcxrle_pkg::CODE_MARK | {2'b00, cnt};
			c.data[1] = val;
			c.n       = 2'd2;
		end
		return c;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign inc_len  = len_q + 6'd1;

	always_comb begin
		nxt_held  = held_q;
		nxt_len   = len_q;
		nxt_start = start_q;
		r0_cnt    = 6'd0;
		r1_cnt    = 6'd0;
		if (start_q) begin
			nxt_held  = pixel;
			nxt_len   = 6'd1;
			nxt_start = 1'b0;
		end else if (pixel == held_q) begin
			if (inc_len == pcxrle_pkg::RUN_MAX) begin
				r0_cnt  = pcxrle_pkg::RUN_MAX;
				nxt_len = 6'd0;
			end else begin
				nxt_len = inc_len;
			end
		end else begin
			r0_cnt   = len_q;
			nxt_held = pixel;
			nxt_len  = 6'd1;
		end
		if (line_end) begin
			r1_cnt    = nxt_len;
			nxt_len   = 6'd0;
			nxt_start = 1'b1;
		end
	end

	assign c0 = run_code(held_q, r0_cnt);
	assign c1 = run_code(nxt_held, r1_cnt);

	always_comb begin
		q_entry.data   = '0;
		q_entry.nbytes = pcxrle_pkg::NB_W'(c0.n) + pcxrle_pkg::NB_W'(c1.n);
		case (c0.n)
			2'd1: begin
				q_entry.data[0] = c0.data[0];
				q_entry.data[1] = c1.data[0];
				q_entry.data[2] = c1.data[1];
			end
			2'd2: begin
				q_entry.data[0] = c0.data[0];
				q_entry.data[1] = c0.data[1];
				q_entry.data[2] = c1.data[0];
				q_entry.data[3] = c1.data[1];
			end
			default: begin
				q_entry.data[0] = c1.data[0];
				q_entry.data[1] = c1.data[1];
			end
		endcase
	end

	assign q_push = accept && (q_entry.nbytes != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 8'd0;
			len_q   <= 6'd0;
			start_q <= 1'b1;
		end else if (accept) begin
			held_q  <= nxt_held;
			len_q   <= nxt_len;
			start_q <= nxt_start;
		end
	end

endmodule

/* rtl/pcxrle_fifo.sv */
module pcxrle_fifo #(
	parameter int WIDTH = pcxrle_pkg::ENTRY_W,
	parameter int DEPTH = pcxrle_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/pcxrle_back.sv */
module pcxrle_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  pcxrle_pkg::entry_t q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_out
);

	logic [pcxrle_pkg::IDX_W-1:0] idx_q;
	logic                         valid_q;
	logic [7:0]                   byte_q;
	logic                         last_q;
	logic                         load;
	logic                         final_byte;

	assign load       = q_not_empty && (!valid_q || out_ready);
	assign final_byte = (pcxrle_pkg::NB_W'(idx_q) + pcxrle_pkg::NB_W'(1)) == q_entry.nbytes;
	assign q_pop      = load && final_byte;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last_out  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= q_entry.data[idx_q];
			last_q <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_byte ? '0 : idx_q + pcxrle_pkg::IDX_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/pcx_rle_line_encoder_top.sv */
// PCX run-length line encoder.
// Input channel: in_valid/in_ready with pixel and line_end; line_end marks
// the last pixel of a scan line and flushes the held run.
// Output channel: out_valid/out_ready with out_byte and last_out; last_out
// is set on the final byte caused by one input transaction.
// Throughput: one pixel per cycle while the transaction queue has room;
// one output byte per cycle while out_ready is high. A pixel leaves 0 to 4
// bytes, so the sustained input rate is set by the single-byte output
// register. Bursts are absorbed by a FIFO_DEPTH-entry queue between the
// run tracker and the byte serialiser.
// Path: the first byte of a transaction is registered in the queue, then in
// the output byte register.
// Reset: queue empty, output idle, run cleared; the next pixel starts a line.
// Receiver stall: the output byte holds, the queue fills, and in_ready drops
// once the queue is full.
module pcx_rle_line_encoder_top #(
	parameter int FIFO_DEPTH = pcxrle_pkg::FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_out
);

	pcxrle_pkg::entry_t wr_entry;
	pcxrle_pkg::entry_t rd_entry;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_not_empty;

	pcxrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel    (pixel),
		.line_end (line_end),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (wr_entry)
	);

	pcxrle_fifo #(
		.WIDTH (pcxrle_pkg::ENTRY_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   (wr_entry),
		.pop       (q_pop),
		.rd_data   (rd_entry),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	pcxrle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (rd_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_out    (last_out)
	);

endmodule

/* rtl/pcxrle_checker.sv */
module pcxrle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] pixel,
	input logic       line_end,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_out
);

	// non-final bytes since the last final byte
	logic [2:0] open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 3'd0;
		end else if (out_valid && out_ready) begin
			if (last_out) begin
				open_q <= 3'd0;
			end else if (open_q != 3'd7) begin
				open_q <= open_q + 3'd1;
			end
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pixel) && $stable(line_end))
		else $error("input transaction changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_out))
		else $error("output transaction changed while stalled");

	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out |-> open_q < 3'd3)
		else $error("more than four bytes for one transaction");

	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid && in_ready)
		else $error("not idle after reset");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) && in_valid && !line_end |=> !out_valid)
		else $error("output without a finished run");

endmodule

bind pcx_rle_line_encoder_top pcxrle_checker u_pcxrle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.pixel     (pixel),
	.line_end  (line_end),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last_out  (last_out)
);
